// File: hw/rtl/u8dec_pkg.sv
package u8dec_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PEND_W   = 2;

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // Default unit limit per name
  localparam int unsigned MAX_UNITS_DEF = 255;

  // End-of-name status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_ENCODING = 2'd1,
    ST_ILLEGAL_NAME = 2'd2,
    ST_TOO_LONG     = 2'd3
  } status_t;

  // Lead and continuation byte classes
  localparam logic [BYTE_W-1:0] MASK_4BYTE = 8'hf0;
  localparam logic [BYTE_W-1:0] MASK_3BYTE = 8'he0;
  localparam logic [BYTE_W-1:0] MASK_2BYTE = 8'hc0;
  localparam logic [BYTE_W-1:0] MASK_HIGH  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;

endpackage

// File: hw/rtl/utf8_to_ucs2_decoder.sv
// Channel  Direction  tdata fields (low bit up)                        tuser
// -------  ---------  -----------------------------------------------  ------
// in_      slave      text_byte[7:0]                                   -
// out_     master     code_unit[15:0] position[23:16] status[25:24]    is_end
//
// One byte is taken per cycle while in_tready is high; decode of a byte
// against the running state (pending count, partial value, unit count,
// discard flag) settles in the same cycle and lands in the output register,
// so a result appears in the cycle after its byte. A stalled result stalls
// the input only while the output register is full and not being drained.
// Synchronous active-low reset clears decode state, empties output register.
module utf8_to_ucs2_decoder #(
  parameter int unsigned MAX_UNITS = u8dec_pkg::MAX_UNITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [u8dec_pkg::IN_DATA_W-1:0]    in_tdata,   // text_byte[7:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // code_unit[15:0], position[23:16], status[25:24], zero pad above
  output logic [u8dec_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                               out_tuser   // is_end
);
  import u8dec_pkg::*;

  localparam logic [POS_W-1:0] UNIT_LIMIT = POS_W'(MAX_UNITS);

  // Decode state
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [UNIT_W-1:0] part_r, part_nxt;
  logic [POS_W-1:0]  count_r, count_nxt;
  logic              discard_r, discard_nxt;

  // Output register
  logic              ovalid_r, ovalid_nxt;
  logic              oend_r, oend_nxt;
  logic [UNIT_W-1:0] ounit_r, ounit_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  status_t           ostat_r, ostat_nxt;

  logic              accept;
  logic [BYTE_W-1:0] c;
  logic [UNIT_W-1:0] part_sh;
  logic [PEND_W-1:0] pend_dec;

  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata[BYTE_W-1:0];
  assign part_sh   = {part_r[UNIT_W-7:0], c[5:0]};
  assign pend_dec  = pend_r - PEND_W'(1);

  // Decode one byte
  always_comb begin
    pend_nxt    = pend_r;
    part_nxt    = part_r;
    count_nxt   = count_r;
    discard_nxt = discard_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    oend_nxt    = oend_r;
    ounit_nxt   = ounit_r;
    opos_nxt    = opos_r;
    ostat_nxt   = ostat_r;
    if (accept) begin
      // defaults for a new result; ovalid decides whether it is shown
      oend_nxt  = 1'b1;
      ounit_nxt = '0;
      opos_nxt  = count_r;
      ostat_nxt = ST_OK;
      if (discard_r) begin
        if (c == '0) begin
          discard_nxt = 1'b0;
          pend_nxt    = '0;
          part_nxt    = '0;
          count_nxt   = '0;
        end
      end else if (pend_r != '0) begin
        if (c == '0) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_BAD_ENCODING;
          pend_nxt   = '0;
          part_nxt   = '0;
          count_nxt  = '0;
        end else if ((c & MASK_2BYTE) != CONT_TAG) begin
          ovalid_nxt  = 1'b1;
          ostat_nxt   = ST_BAD_ENCODING;
          discard_nxt = 1'b1;
          pend_nxt    = '0;
          part_nxt    = '0;
          count_nxt   = '0;
        end else if (pend_dec == '0) begin
          // last continuation: unit complete
          ovalid_nxt = 1'b1;
          oend_nxt   = 1'b0;
          ounit_nxt  = part_sh;
          pend_nxt   = '0;
          part_nxt   = '0;
          count_nxt  = count_r + POS_W'(1);
        end else begin
          pend_nxt = pend_dec;
          part_nxt = part_sh;
        end
      end else if (c == '0) begin
        ovalid_nxt = 1'b1;
        count_nxt  = '0;
        part_nxt   = '0;
      end else if (count_r >= UNIT_LIMIT) begin
        ovalid_nxt  = 1'b1;
        ostat_nxt   = ST_TOO_LONG;
        discard_nxt = 1'b1;
        count_nxt   = '0;
        part_nxt    = '0;
      end else if ((c & MASK_4BYTE) == MASK_4BYTE) begin
        ovalid_nxt  = 1'b1;
        ostat_nxt   = ST_ILLEGAL_NAME;
        discard_nxt = 1'b1;
        count_nxt   = '0;
        part_nxt    = '0;
      end else if ((c & MASK_3BYTE) == MASK_3BYTE) begin
        part_nxt = UNIT_W'(c[3:0]);
        pend_nxt = PEND_W'(2);
      end else if ((c & MASK_2BYTE) == MASK_2BYTE) begin
        part_nxt = UNIT_W'(c[4:0]);
        pend_nxt = PEND_W'(1);
      end else if ((c & MASK_HIGH) != '0) begin
        // stray continuation as lead
        ovalid_nxt  = 1'b1;
        ostat_nxt   = ST_BAD_ENCODING;
        discard_nxt = 1'b1;
        count_nxt   = '0;
        part_nxt    = '0;
      end else begin
        // plain ASCII unit
        ovalid_nxt = 1'b1;
        oend_nxt   = 1'b0;
        ounit_nxt  = UNIT_W'(c);
        count_nxt  = count_r + POS_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      part_r    <= '0;
      count_r   <= '0;
      discard_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      pend_r    <= pend_nxt;
      part_r    <= part_nxt;
      count_r   <= count_nxt;
      discard_r <= discard_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    oend_r  <= oend_nxt;
    ounit_r <= ounit_nxt;
    opos_r  <= opos_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = oend_r;
  assign out_tdata  = {{(OUT_DATA_W-UNIT_W-POS_W-STATUS_W){1'b0}},
                       ostat_r, opos_r, ounit_r};

endmodule

// File: hw/rtl/u8dec_checker.sv
module u8dec_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [u8dec_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import u8dec_pkg::*;

  // Output register is empty coming out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // A stalled result transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // End results carry no code unit
  a_end_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:0] == '0)
    else $error("end result with nonzero code unit");

  // Unit results always report ok status
  a_unit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[25:24] == ST_OK)
    else $error("unit result with error status");

  // Room for the next byte whenever the result side drains
  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready || !out_tvalid |-> in_tready)
    else $error("input stalled with free output register");

endmodule

bind utf8_to_ucs2_decoder u8dec_checker u_u8dec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
